### rtl/running_median_two_heaps_top_macros.svh
// assertion macros for the checker file
`ifndef RUNNING_MEDIAN_TWO_HEAPS_TOP_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RMH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("running median check failed");

// next-cycle implication, sampled on clk, off during reset
`define RMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("running median check failed");

`endif

### rtl/rmh_pkg.sv
package rmh_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed channel field widths
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 11;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // operation applied to every cell of a chain in the same cycle
  typedef enum logic [2:0] {
    CH_NOP,
    CH_CLR,
    CH_INS,
    CH_POP,
    CH_PUSH
  } chain_op_t;

  // command from the controller to both chains
  typedef struct packed {
    chain_op_t lower_op;
    chain_op_t upper_op;
  } chain_cmd_t;

endpackage

### rtl/rmh_ifs.sv
// request channel
interface rmh_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [rmh_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, req_type, sample, input ready);
  modport sink   (input valid, req_type, sample, output ready);
endinterface

// result channel
interface rmh_out_if;
  logic                         valid;
  logic                         ready;
  logic [rmh_pkg::SAMPLE_W-1:0] median;
  logic [rmh_pkg::COUNT_W-1:0]  count;
  logic                         dropped;

  modport source (output valid, median, count, dropped, input ready);
  modport sink   (input valid, median, count, dropped, output ready);
endinterface

### rtl/rmh_cell.sv
module rmh_cell #(
  parameter int DATA_WIDTH = rmh_pkg::DATA_WIDTH_DEF,
  parameter bit IS_MAX     = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmh_pkg::chain_op_t    op,
  input  logic [DATA_WIDTH-1:0] din,
  input  logic [DATA_WIDTH-1:0] left_val,
  input  logic                  left_occ,
  input  logic                  left_keep,
  input  logic [DATA_WIDTH-1:0] right_val,
  input  logic                  right_occ,
  output logic [DATA_WIDTH-1:0] val,
  output logic                  occ,
  output logic                  keep
);

  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  occ_r, occ_nxt;
  logic                  din_ahead;

  // new value ranks strictly ahead of the one held here
  assign din_ahead = IS_MAX ? (din > val_r) : (din < val_r);
  // held value stays put on an insert, ties stay ahead of the new value
  assign keep      = occ_r && !din_ahead;

  assign val = val_r;
  assign occ = occ_r;

  // next value from the chain operation
  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    unique case (op)
      rmh_pkg::CH_NOP: ;
      rmh_pkg::CH_CLR: occ_nxt = 1'b0;
      rmh_pkg::CH_INS: begin
        if (!keep) begin
          if (!left_keep) begin
            val_nxt = left_val;
            occ_nxt = left_occ;
          end else begin
            val_nxt = din;
            occ_nxt = 1'b1;
          end
        end
      end
      rmh_pkg::CH_POP: begin
        val_nxt = right_val;
        occ_nxt = right_occ;
      end
      rmh_pkg::CH_PUSH: begin
        val_nxt = left_val;
        occ_nxt = left_occ;
      end
      default: ;
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // held sample
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### rtl/rmh_chain.sv
module rmh_chain #(
  parameter int DATA_WIDTH = rmh_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH      = rmh_pkg::CAPACITY_DEF / 2,
  parameter bit IS_MAX     = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmh_pkg::chain_op_t    op,
  input  logic [DATA_WIDTH-1:0] din,
  output logic [DATA_WIDTH-1:0] top
);

  logic [DATA_WIDTH-1:0] val_w [DEPTH];
  logic [DEPTH-1:0]      occ_w;
  logic [DEPTH-1:0]      keep_w;

  // sorted row of cells, best-ranked value in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lv;
    logic [DATA_WIDTH-1:0] rv;
    logic                  lo;
    logic                  lk;
    logic                  ro;

    // head cell sees the incoming value as its left neighbour
    if (i == 0) begin : g_head
      assign lv = din;
      assign lo = 1'b1;
      assign lk = 1'b1;
    end else begin : g_body
      assign lv = val_w[i-1];
      assign lo = occ_w[i-1];
      assign lk = keep_w[i-1];
    end

    // tail cell pulls in an empty slot on a pop
    if (i == DEPTH - 1) begin : g_tail
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_mid
      assign rv = val_w[i+1];
      assign ro = occ_w[i+1];
    end

    rmh_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IS_MAX     (IS_MAX)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .din       (din),
      .left_val  (lv),
      .left_occ  (lo),
      .left_keep (lk),
      .right_val (rv),
      .right_occ (ro),
      .val       (val_w[i]),
      .occ       (occ_w[i]),
      .keep      (keep_w[i])
    );
  end

  assign top = val_w[0];

endmodule

### rtl/rmh_ctrl.sv
module rmh_ctrl #(
  parameter int CAPACITY   = rmh_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = rmh_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rmh_in_if.sink                in_ch,
  rmh_out_if.source             out_ch,
  output rmh_pkg::chain_cmd_t   cmd,
  output logic [DATA_WIDTH-1:0] lower_din,
  output logic [DATA_WIDTH-1:0] upper_din,
  input  logic [DATA_WIDTH-1:0] lower_top,
  input  logic [DATA_WIDTH-1:0] upper_top
);

  localparam int Depth   = (CAPACITY + 1) / 2;
  localparam int LcW     = $clog2(Depth + 1);
  localparam int TotW    = LcW + 1;
  localparam int SmpW    = rmh_pkg::SAMPLE_W;
  localparam int OutCntW = rmh_pkg::COUNT_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_STEP2  = 4'b0100,
    ST_RESP   = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  req_r, req_nxt;
  logic [DATA_WIDTH-1:0] smp_r, smp_nxt;
  logic [LcW-1:0]        lcnt_r, lcnt_nxt;
  logic [LcW-1:0]        ucnt_r, ucnt_nxt;
  logic                  drop_r, drop_nxt;
  logic                  s2_ins_r, s2_ins_nxt;
  logic                  out_valid_r;
  logic [SmpW-1:0]       out_median_r;
  logic [OutCntW-1:0]    out_count_r;
  logic                  out_dropped_r;
  logic                  out_load;
  logic [TotW-1:0]       total_w;
  logic                  full_w;
  logic                  to_lower_w;
  logic                  bal_w;

  // occupancy and placement
  assign total_w    = TotW'(lcnt_r) + TotW'(ucnt_r);
  assign full_w     = total_w >= TotW'(CAPACITY);
  assign to_lower_w = (lcnt_r == '0) || (lower_top > smp_r);
  assign bal_w      = lcnt_r == ucnt_r;

  assign in_ch.ready = state_r == ST_IDLE;

  // request sequencer: one or two chain steps per insert that is not dropped
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    smp_nxt    = smp_r;
    lcnt_nxt   = lcnt_r;
    ucnt_nxt   = ucnt_r;
    drop_nxt   = drop_r;
    s2_ins_nxt = s2_ins_r;
    cmd        = '{lower_op: rmh_pkg::CH_NOP, upper_op: rmh_pkg::CH_NOP};
    lower_din  = smp_r;
    upper_din  = smp_r;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          req_nxt   = in_ch.req_type;
          smp_nxt   = DATA_WIDTH'(in_ch.sample);
          drop_nxt  = 1'b0;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_RESP;
        if (req_r == rmh_pkg::REQ_CLEAR) begin
          cmd.lower_op = rmh_pkg::CH_CLR;
          cmd.upper_op = rmh_pkg::CH_CLR;
          lcnt_nxt     = '0;
          ucnt_nxt     = '0;
        end else if (full_w) begin
          drop_nxt = 1'b1;
        end else if (to_lower_w) begin
          if (bal_w) begin
            cmd.lower_op = rmh_pkg::CH_INS;
            lcnt_nxt     = lcnt_r + LcW'(1);
          end else begin
            // lower top moves up first, then the sample goes in below
            cmd.lower_op = rmh_pkg::CH_POP;
            cmd.upper_op = rmh_pkg::CH_PUSH;
            upper_din    = lower_top;
            lcnt_nxt     = lcnt_r - LcW'(1);
            ucnt_nxt     = ucnt_r + LcW'(1);
            s2_ins_nxt   = 1'b1;
            state_nxt    = ST_STEP2;
          end
        end else begin
          cmd.upper_op = rmh_pkg::CH_INS;
          ucnt_nxt     = ucnt_r + LcW'(1);
          if (bal_w) begin
            s2_ins_nxt = 1'b0;
            state_nxt  = ST_STEP2;
          end
        end
      end
      ST_STEP2: begin
        state_nxt = ST_RESP;
        if (s2_ins_r) begin
          cmd.lower_op = rmh_pkg::CH_INS;
          lcnt_nxt     = lcnt_r + LcW'(1);
        end else begin
          // upper top moves down to rebalance
          cmd.upper_op = rmh_pkg::CH_POP;
          cmd.lower_op = rmh_pkg::CH_PUSH;
          lower_din    = upper_top;
          ucnt_nxt     = ucnt_r - LcW'(1);
          lcnt_nxt     = lcnt_r + LcW'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lcnt_r  <= '0;
      ucnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lcnt_r  <= lcnt_nxt;
      ucnt_r  <= ucnt_nxt;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    smp_r    <= smp_nxt;
    drop_r   <= drop_nxt;
    s2_ins_r <= s2_ins_nxt;
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_median_r  <= (lcnt_r == '0) ? '0 : SmpW'(lower_top);
      out_count_r   <= OutCntW'(total_w);
      out_dropped_r <= drop_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.median  = out_median_r;
  assign out_ch.count   = out_count_r;
  assign out_ch.dropped = out_dropped_r;

endmodule

### rtl/running_median_two_heaps_top.sv
// Running median of all samples inserted since the last clear. The samples are held in two
// sorted rows of (CAPACITY+1)/2 cells each: the lower row keeps the smaller half largest-first,
// the upper row the larger half smallest-first, and the head of the lower row is the lower
// median reported with every result (zero while both rows are empty). Each request gives
// one result (median, count, dropped). A request passes from its transfer through a decide
// state, a second step state when placement forces one, and a response state that loads its
// result into the output register once that register is free; the controller runs the rows
// through at most two whole-row shift steps per request. The next request can transfer in the
// cycle after the load, and none is taken before that. A clear empties both rows in a single
// step. An insert while CAPACITY samples are held changes nothing and returns dropped set.
// The output register lets the next request transfer in while a result still waits.
module running_median_two_heaps_top #(
  parameter int CAPACITY   = rmh_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = rmh_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rmh_in_if.sink    in_ch,
  rmh_out_if.source out_ch
);

  localparam int Depth = (CAPACITY + 1) / 2;

  rmh_pkg::chain_cmd_t   cmd;
  logic [DATA_WIDTH-1:0] lower_din;
  logic [DATA_WIDTH-1:0] upper_din;
  logic [DATA_WIDTH-1:0] lower_top;
  logic [DATA_WIDTH-1:0] upper_top;

  // request sequencing and result register
  rmh_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .lower_din (lower_din),
    .upper_din (upper_din),
    .lower_top (lower_top),
    .upper_top (upper_top)
  );

  // smaller half, largest at the head
  rmh_chain #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (Depth),
    .IS_MAX     (1'b1)
  ) u_lower (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (cmd.lower_op),
    .din   (lower_din),
    .top   (lower_top)
  );

  // larger half, smallest at the head
  rmh_chain #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (Depth),
    .IS_MAX     (1'b0)
  ) u_upper (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (cmd.upper_op),
    .din   (upper_din),
    .top   (upper_top)
  );

endmodule

### rtl/running_median_two_heaps_chk.sv
`include "running_median_two_heaps_top_macros.svh"

module running_median_two_heaps_chk #(
  parameter int CAPACITY = rmh_pkg::CAPACITY_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rmh_pkg::SAMPLE_W-1:0] out_median,
  input logic [rmh_pkg::COUNT_W-1:0]  out_count,
  input logic                         out_dropped
);

  localparam int OutCntW = rmh_pkg::COUNT_W;

  // a waiting result holds until its transfer
  `RMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_median) && $stable(out_count) && $stable(out_dropped))

  // a refused insert only happens at capacity
  `RMH_ASSERT_NOW(a_drop_full, out_valid && out_dropped, out_count == OutCntW'(CAPACITY))

  // an empty block reports a zero median
  `RMH_ASSERT_NOW(a_empty_zero, out_valid && (out_count == '0), out_median == '0)

  // count never goes past capacity
  `RMH_ASSERT_NOW(a_count_max, out_valid, int'(out_count) <= CAPACITY)

endmodule

bind running_median_two_heaps_top running_median_two_heaps_chk #(
  .CAPACITY (CAPACITY)
) u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_median  (out_ch.median),
  .out_count   (out_ch.count),
  .out_dropped (out_ch.dropped)
);
